// ----- src/ttt_pkg.sv -----
// Shared types, register indexes and fixed-point constants for the temperature converter.
package ttt_pkg;

	localparam int unsigned ADC_BITS_DEF = 10;

	localparam int unsigned IDX_W = 3;
	localparam int unsigned CFG_W = 20;
	localparam int unsigned OHMS_W = 20;
	localparam int unsigned REF_W = 9;
	localparam int unsigned BETA_W = 14;
	localparam int unsigned COUPLE_W = 14;
	localparam int unsigned TEMP_W = 16;

	typedef enum logic [IDX_W-1:0] {
		REG_SENSOR_SELECT     = 3'd0,
		REG_NOMINAL_OHMS      = 3'd1,
		REG_REFERENCE_CELSIUS = 3'd2,
		REG_BETA_KELVIN       = 3'd3,
		REG_DIVIDER_OHMS      = 3'd4
	} reg_idx_t;

	localparam logic              RST_SENSOR_SELECT     = 1'b1;
	localparam logic [OHMS_W-1:0] RST_NOMINAL_OHMS      = 20'd10000;
	localparam logic [REF_W-1:0]  RST_REFERENCE_CELSIUS = 9'd25;
	localparam logic [BETA_W-1:0] RST_BETA_KELVIN       = 14'd3575;
	localparam logic [OHMS_W-1:0] RST_DIVIDER_OHMS      = 20'd10000;

	// log2 works with 30 fraction bits; ln2 in the same scale.
	localparam int unsigned FRAC_BITS = 30;
	localparam logic [FRAC_BITS-1:0] LN2_Q30 = 30'd744261118;
	localparam int unsigned LOG_DROP = 4;

	// Reference temperature in centikelvin and the beta scale factors.
	localparam int unsigned T0C_W = 16;
	localparam int unsigned T0C_OFFSET = 27315;
	localparam int unsigned CENTI_PER_K = 100;
	localparam int unsigned T80_PER_K = 80;
	localparam int unsigned BK_W = 21;
	localparam int unsigned SCALE_BITS = 26;

	// Quotient in 1/80 K; anything at or above two to this power saturates high.
	localparam int unsigned T80_BITS = 18;
	// floor((t80 - 21852) / 5) is floor((t80 + 3) / 5) - 4371.
	localparam int unsigned T80_BIAS = 3;
	localparam int unsigned DIV5_BIAS = 4371;
	localparam int unsigned DIV5_RECIP_W = 22;
	localparam logic [DIV5_RECIP_W-1:0] DIV5_RECIP = 22'd3355444;
	localparam int unsigned DIV5_SHIFT = 24;

	localparam logic signed [TEMP_W-1:0] TEMP_MIN = -16'sd8192;
	localparam logic signed [TEMP_W-1:0] TEMP_MAX = 16'sd32767;

	typedef logic signed [TEMP_W-1:0] temp_t;

	// Result settled early in the pipeline; later stages pass it along untouched.
	typedef struct packed {
		logic  done;
		logic  ok;
		temp_t temp;
	} ttt_side_t;

endpackage

// ----- src/ttt_in_if.sv -----
// Input channel carrying one sensor sample per request.
interface ttt_in_if #(
	parameter int unsigned ADC_BITS = ttt_pkg::ADC_BITS_DEF
);
	logic                                  valid;
	logic                                  ready;
	logic [ADC_BITS-1:0]                   adc_counts;
	logic signed [ttt_pkg::COUPLE_W-1:0]   couple_quarter_deg;
	logic                                  couple_fault;

	modport source (
		output valid, adc_counts, couple_quarter_deg, couple_fault,
		input  ready
	);
	modport sink (
		input  valid, adc_counts, couple_quarter_deg, couple_fault,
		output ready
	);
endinterface

// ----- src/ttt_out_if.sv -----
// Output channel carrying one temperature per request.
interface ttt_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [ttt_pkg::TEMP_W-1:0]   temp_sixteenths;
	logic                                temp_valid;

	modport source (
		output valid, temp_sixteenths, temp_valid,
		input  ready
	);
	modport sink (
		input  valid, temp_sixteenths, temp_valid,
		output ready
	);
endinterface

// ----- src/ttt_udiv.sv -----
// Pipelined restoring divider, one quotient bit per stage.
module ttt_udiv #(
	parameter int unsigned VW = 11,
	parameter int unsigned QB = 30
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic [VW-1:0]      rem0,
	input  logic [QB-1:0]      dvd,
	input  logic [VW-1:0]      dvs,
	input  ttt_pkg::ttt_side_t in_side,
	output logic               out_valid,
	output logic [QB-1:0]      quo,
	output ttt_pkg::ttt_side_t out_side
);
	import ttt_pkg::*;

	logic [VW-1:0] rem_s [QB];
	logic [QB-1:0] dvd_s [QB];
	logic [QB-1:0] quo_s [QB];
	logic [VW-1:0] dvs_s [QB];
	logic          v_s   [QB];
	ttt_side_t     side_s [QB];

	for (genvar k = 0; k < QB; k++) begin : g_bit
		logic [VW-1:0] rp;
		logic [QB-1:0] np;
		logic [QB-1:0] qp;
		logic [VW-1:0] dp;
		logic          vp;
		ttt_side_t     sp;
		logic [VW:0]   trial;
		logic [VW:0]   diff;
		logic          take;

		if (k == 0) begin : g_first
			assign rp = rem0;
			assign np = dvd;
			assign qp = '0;
			assign dp = dvs;
			assign vp = in_valid;
			assign sp = in_side;
		end else begin : g_next
			assign rp = rem_s[k-1];
			assign np = dvd_s[k-1];
			assign qp = quo_s[k-1];
			assign dp = dvs_s[k-1];
			assign vp = v_s[k-1];
			assign sp = side_s[k-1];
		end

		assign trial = {rp, np[QB-1]};
		assign take  = trial >= {1'b0, dp};
		assign diff  = trial - {1'b0, dp};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= vp;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= take ? diff[VW-1:0] : trial[VW-1:0];
				dvd_s[k]  <= {np[QB-2:0], 1'b0};
				quo_s[k]  <= {qp[QB-2:0], take};
				dvs_s[k]  <= dp;
				side_s[k] <= sp;
			end
		end
	end

	assign out_valid = v_s[QB-1];
	assign quo       = quo_s[QB-1];
	assign out_side  = side_s[QB-1];

endmodule

// ----- src/ttt_log2.sv -----
// Pipelined base-two logarithm of two operands by repeated squaring.
module ttt_log2 #(
	parameter int unsigned XW = 30
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       en,
	input  logic                                       in_valid,
	input  logic [XW-1:0]                              xa,
	input  logic [XW-1:0]                              xb,
	input  ttt_pkg::ttt_side_t                         in_side,
	output logic                                       out_valid,
	output logic [ttt_pkg::FRAC_BITS+$clog2(XW)-1:0]   la,
	output logic [ttt_pkg::FRAC_BITS+$clog2(XW)-1:0]   lb,
	output ttt_pkg::ttt_side_t                         out_side
);
	import ttt_pkg::*;

	localparam int unsigned EW = $clog2(XW);
	localparam int unsigned MW = FRAC_BITS + 1;
	localparam int unsigned SW = XW + FRAC_BITS;

	function automatic logic [EW-1:0] msb_pos(input logic [XW-1:0] x);
		logic [EW-1:0] p;
		p = '0;
		for (int i = 0; i < XW; i++) begin
			if (x[i]) begin
				p = EW'(i);
			end
		end
		return p;
	endfunction

	logic          v_s1, v_s2;
	ttt_side_t     side_s1, side_s2;
	logic [XW-1:0] xa_s1, xb_s1;
	logic [EW-1:0] ea_s1, eb_s1, ea_s2, eb_s2;
	logic [MW-1:0] ma_s2, mb_s2;
	logic [SW-1:0] wa, wb;

	assign wa = {xa_s1, FRAC_BITS'(0)} >> ea_s1;
	assign wb = {xb_s1, FRAC_BITS'(0)} >> eb_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xa_s1   <= xa;
			xb_s1   <= xb;
			ea_s1   <= msb_pos(xa);
			eb_s1   <= msb_pos(xb);
			side_s1 <= in_side;
			ma_s2   <= wa[MW-1:0];
			mb_s2   <= wb[MW-1:0];
			ea_s2   <= ea_s1;
			eb_s2   <= eb_s1;
			side_s2 <= side_s1;
		end
	end

	logic [MW-1:0]        ma_s [FRAC_BITS];
	logic [MW-1:0]        mb_s [FRAC_BITS];
	logic [FRAC_BITS-1:0] fa_s [FRAC_BITS];
	logic [FRAC_BITS-1:0] fb_s [FRAC_BITS];
	logic [EW-1:0]        ea_s [FRAC_BITS];
	logic [EW-1:0]        eb_s [FRAC_BITS];
	logic                 v_s  [FRAC_BITS];
	ttt_side_t            side_s [FRAC_BITS];

	for (genvar k = 0; k < FRAC_BITS; k++) begin : g_sq
		logic [MW-1:0]        map, mbp;
		logic [FRAC_BITS-1:0] fap, fbp;
		logic [EW-1:0]        eap, ebp;
		logic                 vp;
		ttt_side_t            sp;
		logic [2*MW-1:0]      pa, pb;
		logic [MW:0]          ha, hb;

		if (k == 0) begin : g_first
			assign map = ma_s2;
			assign mbp = mb_s2;
			assign fap = '0;
			assign fbp = '0;
			assign eap = ea_s2;
			assign ebp = eb_s2;
			assign vp  = v_s2;
			assign sp  = side_s2;
		end else begin : g_next
			assign map = ma_s[k-1];
			assign mbp = mb_s[k-1];
			assign fap = fa_s[k-1];
			assign fbp = fb_s[k-1];
			assign eap = ea_s[k-1];
			assign ebp = eb_s[k-1];
			assign vp  = v_s[k-1];
			assign sp  = side_s[k-1];
		end

		assign pa = map * map;
		assign pb = mbp * mbp;
		assign ha = pa[FRAC_BITS +: MW+1];
		assign hb = pb[FRAC_BITS +: MW+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= vp;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ma_s[k]   <= ha[MW] ? ha[MW:1] : ha[MW-1:0];
				mb_s[k]   <= hb[MW] ? hb[MW:1] : hb[MW-1:0];
				fa_s[k]   <= {fap[FRAC_BITS-2:0], ha[MW]};
				fb_s[k]   <= {fbp[FRAC_BITS-2:0], hb[MW]};
				ea_s[k]   <= eap;
				eb_s[k]   <= ebp;
				side_s[k] <= sp;
			end
		end
	end

	assign out_valid = v_s[FRAC_BITS-1];
	assign la        = {ea_s[FRAC_BITS-1], fa_s[FRAC_BITS-1]};
	assign lb        = {eb_s[FRAC_BITS-1], fb_s[FRAC_BITS-1]};
	assign out_side  = side_s[FRAC_BITS-1];

endmodule

// ----- src/thermistor_thermocouple_temperature.sv -----
// Top level: thermistor beta-equation converter with thermocouple pass-through.
//
//   channel    direction  handshake          payload
//   samples    in         valid / ready      adc_counts, couple_quarter_deg, couple_fault
//   results    out        valid / ready      temp_sixteenths, temp_valid
//   cfg        in         cfg_we             cfg_idx, cfg_data
//
// One request is taken every cycle unless stalled; each result reaches the output register
// through the resistance divider, the two log squaring chains
// and the 18-step temperature divider.
// Reset clears all valid bits and loads the register defaults; there is no clearing pass.
// When the output register is full and not taken, the whole pipeline holds in place.
module thermistor_thermocouple_temperature #(
	parameter int unsigned ADC_BITS = ttt_pkg::ADC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [ttt_pkg::IDX_W-1:0]   cfg_idx,
	input  logic [ttt_pkg::CFG_W-1:0]   cfg_data,
	ttt_in_if.sink                      samples,
	ttt_out_if.source                   results
);
	import ttt_pkg::*;

	localparam int unsigned AW    = ADC_BITS;
	localparam int unsigned NW    = OHMS_W + ADC_BITS;
	localparam int unsigned LW    = FRAC_BITS + $clog2(NW);
	localparam int unsigned MAGW  = LW - LOG_DROP;
	localparam int unsigned PRODW = T0C_W + MAGW;
	localparam int unsigned DENW  = PRODW + 2;
	localparam int unsigned VW2   = DENW - 1;
	localparam int unsigned NHW   = BK_W + T0C_W;
	localparam int unsigned NUMW  = NHW + SCALE_BITS;
	localparam int unsigned WW    = T80_BITS + 1;
	localparam int unsigned MULW  = WW + DIV5_RECIP_W;
	localparam int unsigned QW    = MULW - DIV5_SHIFT;

	// Configuration registers.
	logic              sensor_select_q;
	logic [OHMS_W-1:0] nominal_ohms_q;
	logic [REF_W-1:0]  reference_celsius_q;
	logic [BETA_W-1:0] beta_kelvin_q;
	logic [OHMS_W-1:0] divider_ohms_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sensor_select_q     <= RST_SENSOR_SELECT;
			nominal_ohms_q      <= RST_NOMINAL_OHMS;
			reference_celsius_q <= RST_REFERENCE_CELSIUS;
			beta_kelvin_q       <= RST_BETA_KELVIN;
			divider_ohms_q      <= RST_DIVIDER_OHMS;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_SENSOR_SELECT:     sensor_select_q     <= cfg_data[0];
				REG_NOMINAL_OHMS:      nominal_ohms_q      <= cfg_data[OHMS_W-1:0];
				REG_REFERENCE_CELSIUS: reference_celsius_q <= cfg_data[REF_W-1:0];
				REG_BETA_KELVIN:       beta_kelvin_q       <= cfg_data[BETA_W-1:0];
				REG_DIVIDER_OHMS:      divider_ohms_q      <= cfg_data[OHMS_W-1:0];
				default: ;
			endcase
		end
	end

	// Global advance: the pipeline moves whenever the output register can take a result.
	logic  adv;
	logic  out_valid_q;
	temp_t out_temp_q;
	logic  out_ok_q;

	assign adv           = !out_valid_q || results.ready;
	assign samples.ready = adv;

	// Stage 1: entry checks, thermocouple path and the divider numerator and divisor.
	logic [AW-1:0]          cnt;
	logic signed [TEMP_W-1:0] couple_x4;
	ttt_side_t              side_in;

	assign cnt       = samples.adc_counts;
	assign couple_x4 = {samples.couple_quarter_deg, 2'b00};

	always_comb begin
		side_in = '0;
		if (!sensor_select_q) begin
			side_in.done = 1'b1;
			side_in.ok   = !samples.couple_fault;
			if (samples.couple_fault) begin
				side_in.temp = '0;
			end else if (couple_x4 < TEMP_MIN) begin
				side_in.temp = TEMP_MIN;
			end else begin
				side_in.temp = couple_x4;
			end
		end else if (cnt == '0 || nominal_ohms_q == '0 || beta_kelvin_q == '0) begin
			side_in.done = 1'b1;
		end
	end

	logic          v_s1;
	ttt_side_t     side_s1;
	logic [NW-1:0] num_s1;
	logic [AW:0]   dvs_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1 <= side_in;
			num_s1  <= NW'(divider_ohms_q) * NW'(cnt);
			dvs_s1  <= {1'b1, AW'(0)} - {1'b0, cnt};
		end
	end

	// Resistance in whole ohms.
	logic          v_d1;
	logic [NW-1:0] r_d1;
	ttt_side_t     side_d1;

	ttt_udiv #(.VW(AW + 1), .QB(NW)) u_rdiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s1),
		.rem0      ('0),
		.dvd       (num_s1),
		.dvs       (dvs_s1),
		.in_side   (side_s1),
		.out_valid (v_d1),
		.quo       (r_d1),
		.out_side  (side_d1)
	);

	ttt_side_t side_r;

	always_comb begin
		side_r = side_d1;
		if (!side_d1.done && r_d1 == '0) begin
			side_r.done = 1'b1;
			side_r.ok   = 1'b0;
			side_r.temp = '0;
		end
	end

	logic          v_l;
	logic [LW-1:0] la, lb;
	ttt_side_t     side_l;

	ttt_log2 #(.XW(NW)) u_log (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_d1),
		.xa        (r_d1),
		.xb        (NW'(nominal_ohms_q)),
		.in_side   (side_r),
		.out_valid (v_l),
		.la        (la),
		.lb        (lb),
		.out_side  (side_l)
	);

	// Config-derived constants of the beta equation.
	logic signed [T0C_W:0] t0c_full;
	logic [T0C_W-1:0]      t0c;
	logic [BK_W-1:0]       b80, b100;
	logic [NHW-1:0]        num_hi;

	assign t0c_full = $signed({{(T0C_W + 1 - REF_W){reference_celsius_q[REF_W-1]}},
			reference_celsius_q}) * $signed((T0C_W + 1)'(CENTI_PER_K))
		+ $signed((T0C_W + 1)'(T0C_OFFSET));
	assign t0c      = t0c_full[T0C_W-1:0];
	assign b80      = BK_W'(beta_kelvin_q) * BK_W'(T80_PER_K);
	assign b100     = BK_W'(beta_kelvin_q) * BK_W'(CENTI_PER_K);
	assign num_hi   = NHW'(b80) * NHW'(t0c);

	// Stages 3 to 6: |ln(R/R0)|, the product with T0 and the denominator.
	logic [LW-1:0]           ldiff;
	logic [MAGW+FRAC_BITS-1:0] lnp;
	logic [PRODW-1:0]        prod;

	logic                    v_s3, v_s4, v_s5, v_s6;
	ttt_side_t               side_s3, side_s4, side_s5, side_s6;
	logic                    neg_s3, neg_s4, neg_s5;
	logic [MAGW-1:0]         mag_s3;
	logic [MAGW-1:0]         l26_s4;
	logic [PRODW-1:0]        prod_s5;
	logic [NUMW-1:0]         num_s5, num_s6;
	logic signed [DENW-1:0]  den_s6;

	assign ldiff = (la < lb) ? (lb - la) : (la - lb);
	assign lnp   = (MAGW + FRAC_BITS)'(mag_s3) * (MAGW + FRAC_BITS)'(LN2_Q30);
	assign prod  = PRODW'(t0c) * PRODW'(l26_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_l;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s3 <= side_l;
			neg_s3  <= la < lb;
			mag_s3  <= ldiff[LW-1:LOG_DROP];
			side_s4 <= side_s3;
			neg_s4  <= neg_s3;
			l26_s4  <= lnp[FRAC_BITS +: MAGW];
			side_s5 <= side_s4;
			neg_s5  <= neg_s4;
			prod_s5 <= prod;
			num_s5  <= {num_hi, SCALE_BITS'(0)};
			side_s6 <= side_s5;
			num_s6  <= num_s5;
			den_s6  <= neg_s5
				? $signed(DENW'({b100, SCALE_BITS'(0)})) - $signed(DENW'(prod_s5))
				: $signed(DENW'({b100, SCALE_BITS'(0)})) + $signed(DENW'(prod_s5));
		end
	end

	// Stage 7: sign and overflow checks ahead of the quotient.
	logic           den_pos;
	logic [VW2-1:0] den_mag;
	logic [VW2-1:0] num_top;
	logic           sat_hi;
	ttt_side_t      side_q;

	assign den_pos = !den_s6[DENW-1] && (den_s6 != '0);
	assign den_mag = den_s6[VW2-1:0];
	assign num_top = VW2'(num_s6[NUMW-1:T80_BITS]);
	assign sat_hi  = num_top >= den_mag;

	always_comb begin
		side_q = side_s6;
		if (!side_s6.done) begin
			if (!den_pos) begin
				side_q.done = 1'b1;
				side_q.ok   = 1'b1;
				side_q.temp = TEMP_MIN;
			end else if (sat_hi) begin
				side_q.done = 1'b1;
				side_q.ok   = 1'b1;
				side_q.temp = TEMP_MAX;
			end
		end
	end

	logic                v_s7;
	ttt_side_t           side_s7;
	logic [VW2-1:0]      rem0_s7;
	logic [T80_BITS-1:0] lo_s7;
	logic [VW2-1:0]      dvs_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s7 <= side_q;
			rem0_s7 <= num_top;
			lo_s7   <= num_s6[T80_BITS-1:0];
			dvs_s7  <= den_pos ? den_mag : VW2'(1);
		end
	end

	logic                v_d2;
	logic [T80_BITS-1:0] t80;
	ttt_side_t           side_d2;

	ttt_udiv #(.VW(VW2), .QB(T80_BITS)) u_tdiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s7),
		.rem0      (rem0_s7),
		.dvd       (lo_s7),
		.dvs       (dvs_s7),
		.in_side   (side_s7),
		.out_valid (v_d2),
		.quo       (t80),
		.out_side  (side_d2)
	);

	// Stage 8: divide by five through the reciprocal; then the output register.
	logic [WW-1:0]   w8;
	logic            v_s8;
	ttt_side_t       side_s8;
	logic [MULW-1:0] mul_s8;
	logic [QW-1:0]   q5;
	logic signed [QW:0] sv;
	temp_t           conv;

	assign w8   = WW'(t80) + WW'(T80_BIAS);
	assign q5   = mul_s8[MULW-1:DIV5_SHIFT];
	assign sv   = $signed({1'b0, q5}) - $signed((QW + 1)'(DIV5_BIAS));
	assign conv = (sv > $signed((QW + 1)'(TEMP_MAX))) ? TEMP_MAX : sv[TEMP_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s8        <= v_d2;
			out_valid_q <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s8    <= side_d2;
			mul_s8     <= MULW'(w8) * MULW'(DIV5_RECIP);
			out_temp_q <= side_s8.done ? side_s8.temp : conv;
			out_ok_q   <= side_s8.done ? side_s8.ok : 1'b1;
		end
	end

	assign results.valid           = out_valid_q;
	assign results.temp_sixteenths = out_temp_q;
	assign results.temp_valid      = out_ok_q;

`ifndef ASSERT_OFF
	a_invalid_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && !results.temp_valid |-> results.temp_sixteenths == '0)
		else $error("Invalid result carries a nonzero temperature.");

	a_floor: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> results.temp_sixteenths >= TEMP_MIN)
		else $error("Result lies below the saturation floor.");

	a_couple_grid: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && !sensor_select_q |-> results.temp_sixteenths[1:0] == 2'b00)
		else $error("Thermocouple result is off the quarter-degree grid.");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		v_s8 && !adv |=> v_s8 && $stable(mul_s8))
		else $error("Pipeline stage changed while stalled.");
`endif

endmodule
